// ----- hdl/ahx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahx_pkg
// Shared types, constants and the permutation round for the Ascon
// hash / XOF sponge engine.
// ----------------------------------------------------------------------------
package ahx_pkg;

    localparam int ROUNDS        = 12;
    localparam int MAX_OUT_WORDS = 64;
    localparam int MAX_OUT_BYTES = MAX_OUT_WORDS * 8;
    localparam int HASH_BYTES    = 32;

    localparam int WORDS_W = $clog2(MAX_OUT_WORDS + 1);
    localparam int RND_W   = 4;

    localparam logic [63:0] IV_HASH = 64'h0000_0801_00cc_0002;
    localparam logic [63:0] IV_XOF  = 64'h0000_0800_00cc_0003;
    localparam logic [7:0]  PAD_BYTE = 8'h01;

    // first round constant index of a permutation
    localparam logic [RND_W-1:0] RC_START = RND_W'(16 - ROUNDS);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    // configuration register indexes
    localparam logic CFG_XOF_MODE  = 1'b0;
    localparam logic CFG_OUT_BYTES = 1'b1;

    typedef logic [4:0][63:0] t_lanes;

    typedef struct packed {
        logic             capture;
        logic             load_iv;
        logic             iv_xof;
        logic             absorb_full;
        logic             absorb_pad;
        logic             xor_one;
        logic             round_en;
        logic [RND_W-1:0] round_idx;
        logic             emit;
        logic [3:0]       emit_vb;
        logic             emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic blk_full;
    } t_dp_status;

    function automatic logic [7:0] ahx_rc(input logic [3:0] idx);
        logic [7:0] rc;
        case (idx)
            4'd0:    rc = 8'h3c;
            4'd1:    rc = 8'h2d;
            4'd2:    rc = 8'h1e;
            4'd3:    rc = 8'h0f;
            4'd4:    rc = 8'hf0;
            4'd5:    rc = 8'he1;
            4'd6:    rc = 8'hd2;
            4'd7:    rc = 8'hc3;
            4'd8:    rc = 8'hb4;
            4'd9:    rc = 8'ha5;
            4'd10:   rc = 8'h96;
            4'd11:   rc = 8'h87;
            4'd12:   rc = 8'h78;
            4'd13:   rc = 8'h69;
            4'd14:   rc = 8'h5a;
            default: rc = 8'h4b;
        endcase
        return rc;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // low c bytes set; c of 8 or more selects the whole word
    function automatic logic [63:0] byte_mask(input logic [3:0] c);
        logic [63:0] m;
        for (int j = 0; j < 8; j++) begin
            m[8*j +: 8] = (4'(j) < c) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic t_lanes ahx_round(input t_lanes s, input logic [7:0] rc);
        logic [63:0] x0, x1, x2, x3, x4;
        logic [63:0] t0, t1, t2, t3, t4;
        t_lanes      r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, rc};
        x3 = s[3];
        x4 = s[4];
        // substitution layer
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x1 & x2;
        t1 = ~x2 & x3;
        t2 = ~x3 & x4;
        t3 = ~x4 & x0;
        t4 = ~x0 & x1;
        x0 = x0 ^ t0;
        x1 = x1 ^ t1;
        x2 = x2 ^ t2;
        x3 = x3 ^ t3;
        x4 = x4 ^ t4;
        x1 = x1 ^ x0;
        x3 = x3 ^ x2;
        x0 = x0 ^ x4;
        x2 = ~x2;
        // linear diffusion layer
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
        return r;
    endfunction

endpackage

// ----- hdl/ahx_blk_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahx_blk_if
// Message block channel: valid/ready with one block per transaction.
// ----------------------------------------------------------------------------
interface ahx_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_block;

    modport source (output valid, message_word, byte_count, last_block, input ready);
    modport sink   (input valid, message_word, byte_count, last_block, output ready);
endinterface

// ----- hdl/ahx_dig_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahx_dig_if
// Digest word channel: valid/ready with one output word per transaction.
// ----------------------------------------------------------------------------
interface ahx_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [3:0]  valid_bytes;
    logic        last_word;

    modport source (output valid, digest_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, digest_word, valid_bytes, last_word, output ready);
endinterface

// ----- hdl/ascon_hash_xof_sponge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_hash_xof_sponge
// Ascon-Hash256 / Ascon-XOF128 sponge engine, 64-bit rate.
// ----------------------------------------------------------------------------
// Blocks arrive on i_blk one transaction at a time; the engine takes a new
// block only when the previous one is fully processed. The permutation runs
// one round per cycle, 12 rounds per permutation. A non-final block is
// accepted, absorbed and permuted; the first block of a message adds the IV
// load and its permutation. A final block adds a padding block and its
// permutation when it is a full 8 bytes, and each output word takes a
// permutation plus the load of the output register, plus any stall on
// o_dig. The output register lets the next message start while the last
// digest word is still waiting. Configuration: index 0 is xof_mode, index 1
// is out_bytes (XOF length, 0 read as 1, capped at 512); write only while idle.
// ----------------------------------------------------------------------------
module ascon_hash_xof_sponge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    ahx_blk_if.sink     i_blk,
    ahx_dig_if.source   o_dig
);
    import ahx_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ahx_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_blk_valid  (i_blk.valid),
        .o_blk_ready  (i_blk.ready),
        .i_last_block (i_blk.last_block),
        .o_dig_valid  (o_dig.valid),
        .i_dig_ready  (o_dig.ready),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    ahx_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_message_word (i_blk.message_word),
        .i_byte_count   (i_blk.byte_count),
        .o_status       (status),
        .o_digest_word  (o_dig.digest_word),
        .o_valid_bytes  (o_dig.valid_bytes),
        .o_last_word    (o_dig.last_word)
    );

endmodule

// ----- hdl/ahx_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahx_datapath
// Sponge state (five lanes), one permutation round per cycle, block
// holding register and the output word register.
// ----------------------------------------------------------------------------
module ahx_datapath (
    input  logic                 i_clk,
    input  ahx_pkg::t_dp_cmd     i_cmd,
    input  logic [63:0]          i_message_word,
    input  logic [3:0]           i_byte_count,
    output ahx_pkg::t_dp_status  o_status,
    output logic [63:0]          o_digest_word,
    output logic [3:0]           o_valid_bytes,
    output logic                 o_last_word
);
    import ahx_pkg::*;

    t_lanes      r_lanes;
    logic [63:0] r_msg;
    logic [3:0]  r_cnt;
    logic [63:0] r_dig;
    logic [3:0]  r_vb;
    logic        r_last;

    logic [63:0] pad_bits;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            pad_bits[8*j +: 8] = (3'(j) == r_cnt[2:0]) ? PAD_BYTE : 8'h00;
        end
    end

    assign o_status.blk_full = r_cnt[3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_msg <= i_message_word;
            r_cnt <= i_byte_count;
        end

        if (i_cmd.load_iv) begin
            // IV in lane 0, other lanes cleared
            r_lanes <= {{4{64'd0}}, (i_cmd.iv_xof ? IV_XOF : IV_HASH)};
        end else if (i_cmd.absorb_full) begin
            r_lanes[0] <= r_lanes[0] ^ r_msg;
        end else if (i_cmd.absorb_pad) begin
            // partial last block: keep its bytes, padding byte right after
            r_lanes[0] <= r_lanes[0] ^ (r_msg & byte_mask(r_cnt)) ^ pad_bits;
        end else if (i_cmd.xor_one) begin
            r_lanes[0] <= r_lanes[0] ^ {56'd0, PAD_BYTE};
        end else if (i_cmd.round_en) begin
            r_lanes <= ahx_round(r_lanes, ahx_rc(i_cmd.round_idx));
        end

        if (i_cmd.emit) begin
            r_dig  <= r_lanes[0] & byte_mask(i_cmd.emit_vb);
            r_vb   <= i_cmd.emit_vb;
            r_last <= i_cmd.emit_last;
        end
    end

    assign o_digest_word = r_dig;
    assign o_valid_bytes = r_vb;
    assign o_last_word   = r_last;

endmodule

// ----- hdl/ahx_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahx_ctrl
// Sponge sequencer: configuration registers, block and output handshakes,
// round counter and squeeze word count.
// ----------------------------------------------------------------------------
module ahx_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [9:0]           i_cfg_data,
    input  logic                 i_blk_valid,
    output logic                 o_blk_ready,
    input  logic                 i_last_block,
    output logic                 o_dig_valid,
    input  logic                 i_dig_ready,
    output ahx_pkg::t_dp_cmd     o_cmd,
    input  ahx_pkg::t_dp_status  i_status
);
    import ahx_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_IV       = 3'd1;
    localparam logic [2:0] S_PERM_IV  = 3'd2;
    localparam logic [2:0] S_ABSORB   = 3'd3;
    localparam logic [2:0] S_PERM_ABS = 3'd4;
    localparam logic [2:0] S_PAD      = 3'd5;
    localparam logic [2:0] S_PERM_SQ  = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]         r_state,      n_state;
    logic [RND_W-1:0]   r_rnd,        n_rnd;
    logic               r_msg_start,  n_msg_start;
    logic               r_last,       n_last;
    logic [WORDS_W-1:0] r_words_left, n_words_left;
    logic [3:0]         r_last_vb,    n_last_vb;
    logic               r_out_valid,  n_out_valid;
    logic               r_xof;
    logic [9:0]         r_out_bytes;

    logic       accept;
    logic       rnd_done;
    logic       final_word;
    logic [9:0] total;
    logic [10:0] total_rnd;

    assign o_blk_ready = (r_state == S_IDLE);
    assign accept      = i_blk_valid && o_blk_ready;
    assign rnd_done    = (r_rnd == RND_LAST);
    assign final_word  = (r_words_left == WORDS_W'(1));
    assign o_dig_valid = r_out_valid;

    // output length in bytes, clamped to 1..MAX_OUT_BYTES in XOF mode
    always_comb begin
        if (!r_xof) begin
            total = 10'(HASH_BYTES);
        end else if (r_out_bytes == 10'd0) begin
            total = 10'd1;
        end else if (r_out_bytes > 10'(MAX_OUT_BYTES)) begin
            total = 10'(MAX_OUT_BYTES);
        end else begin
            total = r_out_bytes;
        end
        total_rnd = {1'b0, total} + 11'd7;
    end

    always_comb begin
        n_state      = r_state;
        n_rnd        = r_rnd;
        n_msg_start  = r_msg_start;
        n_last       = r_last;
        n_words_left = r_words_left;
        n_last_vb    = r_last_vb;

        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.iv_xof    = r_xof;
        o_cmd.round_idx = RC_START + r_rnd;

        unique case (r_state) inside
            S_IDLE: begin
                if (accept) begin
                    n_last  = i_last_block;
                    n_state = r_msg_start ? S_IV : S_ABSORB;
                end
            end
            S_IV: begin
                o_cmd.load_iv = 1'b1;
                n_msg_start   = 1'b0;
                n_rnd         = '0;
                n_state       = S_PERM_IV;
            end
            S_ABSORB: begin
                n_rnd = '0;
                if (!r_last) begin
                    o_cmd.absorb_full = 1'b1;
                    n_state           = S_PERM_ABS;
                end else begin
                    n_msg_start  = 1'b1;
                    n_words_left = total_rnd[WORDS_W+2:3];
                    n_last_vb    = (total[2:0] == 3'd0) ? 4'd8 : {1'b0, total[2:0]};
                    if (i_status.blk_full) begin
                        // full last block, then an empty padding block
                        o_cmd.absorb_full = 1'b1;
                        n_state           = S_PERM_ABS;
                    end else begin
                        o_cmd.absorb_pad = 1'b1;
                        n_state          = S_PERM_SQ;
                    end
                end
            end
            S_PAD: begin
                o_cmd.xor_one = 1'b1;
                n_rnd         = '0;
                n_state       = S_PERM_SQ;
            end
            S_PERM_IV, S_PERM_ABS, S_PERM_SQ: begin
                o_cmd.round_en = 1'b1;
                n_rnd          = r_rnd + 1'b1;
                if (rnd_done) begin
                    n_rnd = '0;
                    case (r_state)
                        S_PERM_IV:  n_state = S_ABSORB;
                        S_PERM_ABS: n_state = r_last ? S_PAD : S_IDLE;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_dig_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_vb   = final_word ? r_last_vb : 4'd8;
                    o_cmd.emit_last = final_word;
                    n_words_left    = r_words_left - 1'b1;
                    n_state         = final_word ? S_IDLE : S_PERM_SQ;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_dig_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rnd        <= '0;
            r_msg_start  <= 1'b1;
            r_last       <= 1'b0;
            r_words_left <= '0;
            r_last_vb    <= 4'd8;
            r_out_valid  <= 1'b0;
            r_xof        <= 1'b0;
            r_out_bytes  <= 10'd32;
        end else begin
            r_state      <= n_state;
            r_rnd        <= n_rnd;
            r_msg_start  <= n_msg_start;
            r_last       <= n_last;
            r_words_left <= n_words_left;
            r_last_vb    <= n_last_vb;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_XOF_MODE:  r_xof       <= i_cfg_data[0];
                    CFG_OUT_BYTES: r_out_bytes <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

endmodule

// ----- bench/ascon_hash_xof_sponge_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_hash_xof_sponge_test
// Self-checking bench for the Ascon hash / XOF sponge engine. Message blocks
// go in on the block channel and a bench-side sponge works out the digest
// words each final block must produce. Every digest transaction is checked
// field by field against the oldest pending word. Directed cases cover the
// padding corners, XOF lengths and a mid-message mode switch. A long output
// stall fills the engine, and random multi-block messages run over many
// register settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module ascon_hash_xof_sponge_test;
    import ahx_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TOTAL_BLOCKS = 370;
    localparam int SETTLE       = 64;   // covers IV load + block + padding permutations

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        fin;
    } digest_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [9:0] cfg_data;

    ahx_blk_if blk();
    ahx_dig_if dig();

    ascon_hash_xof_sponge dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_blk      (blk),
        .o_dig      (dig)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench-side sponge state and register copies
    logic [63:0] st [5];
    bit          at_start  = 1'b1;
    bit          mode_xof  = 1'b0;
    logic [9:0]  xof_len   = 10'd32;

    digest_t digest_q[$];
    int      errors       = 0;
    int      blocks_sent  = 0;
    int      cycles       = 0;
    int      hold_request = 0;
    bit      idling       = 1'b1;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void sponge_round(input logic [3:0] idx);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        logic [3:0]  hi, lo;
        hi = 4'd3 - idx;
        lo = 4'hc + idx;
        x0 = st[0];
        x1 = st[1];
        x2 = st[2] ^ {56'd0, hi, lo};
        x3 = st[3];
        x4 = st[4];
        x0 ^= x4;  x4 ^= x3;  x2 ^= x1;
        t0 = ~x1 & x2;  t1 = ~x2 & x3;  t2 = ~x3 & x4;  t3 = ~x4 & x0;  t4 = ~x0 & x1;
        x0 ^= t0;  x1 ^= t1;  x2 ^= t2;  x3 ^= t3;  x4 ^= t4;
        x1 ^= x0;  x3 ^= x2;  x0 ^= x4;  x2 = ~x2;
        st[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
        st[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
        st[2] = x2 ^ ror64(x2, 1)  ^ ror64(x2, 6);
        st[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
        st[4] = x4 ^ ror64(x4, 7)  ^ ror64(x4, 41);
    endfunction

    function automatic void permute();
        for (int i = 0; i < ROUNDS; i++) begin
            sponge_round(4'(16 - ROUNDS + i));
        end
    endfunction

    // absorbs one block; a final block also queues the digest words it yields
    function automatic void absorb_block(input logic [63:0] w, input logic [3:0] c,
                                         input logic l);
        int          n, total, nwords, vb;
        digest_t     d;
        if (at_start) begin
            st       = '{default: '0};
            st[0]    = mode_xof ? IV_XOF : IV_HASH;
            permute();
            at_start = 1'b0;
        end
        if (!l) begin
            // byte_count is ignored on non-final blocks
            st[0] ^= w;
            permute();
        end else begin
            n = (c > 4'd8) ? 8 : int'(c);
            if (n == 8) begin
                st[0] ^= w;
                permute();
                st[0] ^= 64'd1;
            end else begin
                st[0] ^= (w & ((n == 0) ? 64'd0 : ({64{1'b1}} >> (64 - 8 * n))))
                         ^ (64'd1 << (8 * n));
            end
            at_start = 1'b1;
            if (!mode_xof)                  total = HASH_BYTES;
            else if (xof_len == 0)          total = 1;
            else if (xof_len > MAX_OUT_BYTES) total = MAX_OUT_BYTES;
            else                            total = int'(xof_len);
            nwords = (total + 7) / 8;
            for (int k = 0; k < nwords; k++) begin
                permute();
                d.word = st[0];
                vb     = 8;
                if (k == nwords - 1) begin
                    vb = total - 8 * k;
                    if (vb < 8) d.word &= {64{1'b1}} >> (64 - 8 * vb);
                end
                d.nbytes = 4'(vb);
                d.fin    = (k == nwords - 1);
                digest_q.push_back(d);
            end
        end
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    task automatic send_block(input logic [63:0] w, input logic [3:0] c, input logic l);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            blk.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk.valid        <= 1'b1;
        blk.message_word <= w;
        blk.byte_count   <= c;
        blk.last_block   <= l;
        @(posedge i_clk);
        while (!blk.ready) @(posedge i_clk);
        absorb_block(w, c, l);
        blocks_sent++;
    endtask

    // drop valid, wait for every pending word, then let the engine go quiet
    task automatic settle_idle();
        blk.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_XOF_MODE) mode_xof = data[0];
        else                     xof_len  = data;
    endtask

    // output side: random stall bursts, plus a long hold when requested
    initial begin : sink_side
        int stall, hold;
        stall = 0;
        hold  = 0;
        dig.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n) begin
                dig.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                dig.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                dig.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 18);
                dig.ready <= 1'b0;
            end else begin
                dig.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_digest
        digest_t d;
        if (i_rst_n && dig.valid && dig.ready) begin
            if (digest_q.size() == 0) begin
                $error("digest_word: expected none, got %h", dig.digest_word);
                errors++;
            end else begin
                d = digest_q.pop_front();
                if (dig.digest_word !== d.word) begin
                    $error("digest_word: expected %h, got %h", d.word, dig.digest_word);
                    errors++;
                end
                if (dig.valid_bytes !== d.nbytes) begin
                    $error("valid_bytes: expected %0d, got %0d", d.nbytes, dig.valid_bytes);
                    errors++;
                end
                if (dig.last_word !== d.fin) begin
                    $error("last_word: expected %0b, got %0b", d.fin, dig.last_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset defaults first (hash mode), then the padding corners
    task automatic test_known_hash_cases();
        send_block(64'h0123_4567_89ab_cdef, 4'd0, 1'b1);   // empty message
        send_block('1, 4'd8, 1'b1);                         // full final -> pad block
        send_block('0, 4'd8, 1'b0);
        send_block('1, 4'd7, 1'b1);
        send_block(rand_word(), 4'd3, 1'b0);                // short non-final absorbed whole
        send_block(rand_word(), 4'd5, 1'b1);
        send_block(rand_word(), 4'd15, 1'b1);               // oversized counts read as 8
        send_block(rand_word(), 4'd9, 1'b1);
        settle_idle();
    endtask

    task automatic test_xof_lengths();
        logic [9:0] lens [7] = '{10'd0, 10'd1, 10'd7, 10'd8, 10'd9, 10'd512, 10'd1023};
        write_reg(CFG_XOF_MODE, 10'h3ff);
        foreach (lens[i]) begin
            write_reg(CFG_OUT_BYTES, lens[i]);
            send_block(rand_word(), 4'($urandom_range(0, 8)), 1'b1);
            settle_idle();
        end
    endtask

    // IV comes from the mode at the first block, output length from the last
    task automatic test_mode_switch();
        write_reg(CFG_OUT_BYTES, 10'd21);
        write_reg(CFG_XOF_MODE, 10'd0);
        send_block(rand_word(), 4'd8, 1'b0);
        settle_idle();
        write_reg(CFG_XOF_MODE, 10'd1);
        send_block(rand_word(), 4'd4, 1'b1);
        settle_idle();
        send_block(rand_word(), 4'd8, 1'b0);
        settle_idle();
        write_reg(CFG_XOF_MODE, 10'd0);
        send_block(rand_word(), 4'd2, 1'b1);
        settle_idle();
    endtask

    // long output hold while blocks keep coming: engine must stall its input
    task automatic test_output_backpressure();
        hold_request = 300;
        repeat (4) send_block(rand_word(), 4'd8, 1'b1);
        settle_idle();
    endtask

    task automatic test_random_messages();
        int phase_items, nblk, r;
        bit clean;
        while (blocks_sent < TOTAL_BLOCKS) begin
            idling = (blocks_sent < TOTAL_BLOCKS - 40);
            write_reg(CFG_XOF_MODE, {9'($urandom), 1'($urandom_range(0, 1))});
            r = $urandom_range(0, 9);
            if (r < 6)      write_reg(CFG_OUT_BYTES, 10'($urandom_range(1, 40)));
            else if (r < 8) write_reg(CFG_OUT_BYTES, 10'($urandom_range(41, 128)));
            else if (r < 9) write_reg(CFG_OUT_BYTES, 10'($urandom_range(129, 1023)));
            else            write_reg(CFG_OUT_BYTES, 10'($urandom_range(0, 1)));
            phase_items = 0;
            while (phase_items < 30 && blocks_sent < TOTAL_BLOCKS) begin
                clean = ($urandom_range(0, 6) != 0);
                nblk  = $urandom_range(1, 5);
                for (int b = 1; b < nblk; b++) begin
                    send_block(rand_word(), clean ? 4'd8 : 4'($urandom_range(0, 15)), 1'b0);
                end
                send_block(rand_word(),
                           clean ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15)),
                           1'b1);
                phase_items += nblk;
            end
            settle_idle();
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= 1'b0;
        cfg_data         <= '0;
        blk.valid        <= 1'b0;
        blk.message_word <= '0;
        blk.byte_count   <= '0;
        blk.last_block   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_known_hash_cases();
        test_xof_lengths();
        test_mode_switch();
        test_output_backpressure();
        test_random_messages();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
